/* src/forwarding_table_exact_match_defines.svh */
// Assertion macros shared by the forwarding table RTL.
`ifndef FORWARDING_TABLE_EXACT_MATCH_DEFINES_SVH
`define FORWARDING_TABLE_EXACT_MATCH_DEFINES_SVH

// Same-cycle implication, sampled on aclk, quiet while aresetn is low.
`define FTEM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, quiet while aresetn is low.
`define FTEM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fte_pkg.sv */
// Types and constants of the exact-match forwarding table.
`default_nettype none

package fte_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 8;
    localparam int EC_W        = 5;

    localparam logic OP_MAP    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [ADDR_W-1:0] address;
        logic        [PORT_W-1:0] port;
    } req_t;

    typedef struct packed {
        logic              accepted;
        logic [PORT_W-1:0] found_port;
        logic              hit;
        logic [EC_W-1:0]   entry_count;
    } res_t;

    // Item traveling down the cell chain.
    typedef struct packed {
        logic                     vld;
        logic                     live;
        logic                     op;
        logic signed [ADDR_W-1:0] address;
        logic        [PORT_W-1:0] port;
        logic        [CNT_W-1:0]  remain;
        logic                     hit;
        logic                     appended;
        logic        [PORT_W-1:0] found;
    } tok_t;

endpackage

`default_nettype wire

/* src/forwarding_table_exact_match.sv */
// Top level of the exact-match forwarding table with default route.
`default_nettype none
`include "forwarding_table_exact_match_defines.svh"

// Exact-match forwarding table built as a row of TABLE_DEPTH cells, one entry
// per cell. An accepted beat walks the row one cell per cycle while the row is
// not held; each cell compares its stored address, updates its port on a map
// hit, returns it on a lookup hit, and the first unused cell takes a new entry
// on a map miss. A map beat is refused when all TABLE_DEPTH entries are in
// use. The result leaves the last cell's register and is registered on m_.
// Only one item is in the row at a time, so a new beat is taken only once the
// item before it has left the row; the row is held while a finished item at
// the row end waits behind a result on m_ that m_ready has not taken. A result
// waiting on m_ does not block the next input beat. The default port register
// is written through cfg_ and is applied on lookup misses; 0 means no default route.
module forwarding_table_exact_match (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output      logic                        s_ready,
    input  wire fte_pkg::req_t               s_data,
    output      logic                        m_valid,
    input  wire logic                        m_ready,
    output fte_pkg::res_t                    m_data,
    input  wire logic                        cfg_valid,
    output      logic                        cfg_ready,
    input  wire logic [fte_pkg::PORT_W-1:0]  cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic                       state_reg;
    logic                       state_next;
    logic [fte_pkg::CNT_W-1:0]  count_reg;
    logic [fte_pkg::CNT_W-1:0]  count_next;
    logic [fte_pkg::PORT_W-1:0] dflt_reg;
    logic                       m_valid_reg;
    fte_pkg::res_t              m_data_reg;
    fte_pkg::res_t              res_next;
    fte_pkg::tok_t              chain [fte_pkg::TABLE_DEPTH+1];
    fte_pkg::tok_t              tail;
    logic                       accept;
    logic                       advance;
    logic                       take;
    logic                       full;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == fte_pkg::CNT_W'(fte_pkg::TABLE_DEPTH));

    // Hold the row only while a finished item cannot leave.
    assign tail    = chain[fte_pkg::TABLE_DEPTH];
    assign advance = !(tail.vld && m_valid_reg && !m_ready);
    assign take    = tail.vld && advance;

    always_comb begin
        chain[0].vld      = accept;
        chain[0].live     = !((s_data.op == fte_pkg::OP_MAP) && full);
        chain[0].op       = s_data.op;
        chain[0].address  = s_data.address;
        chain[0].port     = s_data.port;
        chain[0].remain   = count_reg;
        chain[0].hit      = 1'b0;
        chain[0].appended = 1'b0;
        chain[0].found    = '0;
    end

    for (genvar i = 0; i < fte_pkg::TABLE_DEPTH; i++) begin : g_cell
        fte_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .tok_i   (chain[i]),
            .tok_o   (chain[i+1])
        );
    end

    assign count_next = count_reg + fte_pkg::CNT_W'(tail.appended);

    always_comb begin
        res_next.accepted    = tail.live;
        res_next.hit         = tail.hit;
        res_next.entry_count = fte_pkg::EC_W'(count_next);
        if (tail.op == fte_pkg::OP_MAP) begin
            res_next.found_port = '0;
        end else if (tail.hit) begin
            res_next.found_port = tail.found;
        end else begin
            res_next.found_port = dflt_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dflt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                dflt_reg <= cfg_data;
            end
            if (take) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `FTEM_ASSERT_IMPL(a_count_max, 1'b1, count_reg <= fte_pkg::CNT_W'(fte_pkg::TABLE_DEPTH), "entry count beyond table depth")
    `FTEM_ASSERT_IMPL(a_idle_empty, state_reg == ST_IDLE, !tail.vld, "item at row end while idle")
    `FTEM_ASSERT_NEXT(a_count_step, take, count_reg == $past(count_next), "entry count not advanced by retiring item")
    `FTEM_ASSERT_IMPL(a_refused_quiet, tail.vld && !tail.live, !tail.hit && !tail.appended, "refused map touched the table")
    `FTEM_ASSERT_IMPL(a_lookup_no_append, tail.vld && (tail.op == fte_pkg::OP_LOOKUP), !tail.appended, "lookup appended an entry")

endmodule

`default_nettype wire

/* src/fte_cell.sv */
// One table entry: compares the passing item, updates or appends, hands the item on.
`default_nettype none

module fte_cell (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         advance,
    input  wire fte_pkg::tok_t tok_i,
    output fte_pkg::tok_t     tok_o
);

    logic signed [fte_pkg::ADDR_W-1:0] addr_reg;
    logic        [fte_pkg::PORT_W-1:0] port_reg;
    fte_pkg::tok_t                     tok_reg;
    fte_pkg::tok_t                     tok_next;
    logic                              occupied;
    logic                              match;
    logic                              append;

    // The entry is in use while the item still has stored entries ahead of it.
    assign occupied = (tok_i.remain != '0);
    assign match    = tok_i.vld && tok_i.live && occupied && !tok_i.hit
                      && (addr_reg == tok_i.address);
    assign append   = tok_i.vld && tok_i.live && (tok_i.op == fte_pkg::OP_MAP)
                      && !occupied && !tok_i.appended && !tok_i.hit;

    always_comb begin
        tok_next          = tok_i;
        tok_next.hit      = tok_i.hit | match;
        tok_next.appended = tok_i.appended | append;
        if (match && (tok_i.op == fte_pkg::OP_LOOKUP)) begin
            tok_next.found = port_reg;
        end
        if (occupied) begin
            tok_next.remain = tok_i.remain - fte_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (append) begin
                addr_reg <= tok_i.address;
                port_reg <= tok_i.port;
            end else if (match && (tok_i.op == fte_pkg::OP_MAP)) begin
                port_reg <= tok_i.port;
            end
        end
    end

    // Clear only the valid bit on reset; the payload of the passing item holds.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
        end else if (advance) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_o = tok_reg;

endmodule

`default_nettype wire
